// ----- rtl/rc5_pkg.sv -----
// Shared types, constants and rotate helpers for the RC5-16 block cipher.
// Used by rc5_ctrl, rc5_datapath and rc5_block_cipher; depends on nothing.
package rc5_pkg;

  localparam int WORD_W    = 16;
  localparam int KEY_W     = 64;
  localparam int KEY_WORDS = 4;
  localparam int KW_IDX_W  = 2;

  localparam logic [WORD_W-1:0] MAGIC_P   = 16'hB7E1;
  localparam logic [WORD_W-1:0] MAGIC_Q   = 16'h9E37;
  localparam logic [3:0]        SCHED_ROT = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_MIX,
    ST_START,
    ST_CRYPT,
    ST_HOLD
  } rc5_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                blk_load;
    logic                sched_init;
    logic                fill_we;
    logic                mix_we;
    logic                rd_en;
    logic                crypt_en;
    logic                crypt_white;
    logic                out_load;
    logic [KW_IDX_W-1:0] key_idx;
  } rc5_cmd_t;

  function automatic logic [WORD_W-1:0] rotl16(input logic [WORD_W-1:0] x,
                                               input logic [3:0] s);
    logic [2*WORD_W-1:0] d;
    d = {x, x} << s;
    return d[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] rotr16(input logic [WORD_W-1:0] x,
                                               input logic [3:0] s);
    logic [2*WORD_W-1:0] d;
    d = {x, x} >> s;
    return d[WORD_W-1:0];
  endfunction

endpackage

// ----- rtl/rc5_ctrl.sv -----
// Controller FSM for the RC5-16 block cipher: key expansion sequencing,
// round stepping, round-key table addressing and the output handshake. Uses rc5_pkg.
module rc5_ctrl import rc5_pkg::*; #(
  parameter int ROUNDS = 8,
  parameter int IDX_W  = $clog2(2 * (ROUNDS + 1))
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic             dec_mode,
  output rc5_cmd_t         cmd,
  output logic [IDX_W-1:0] wr_idx,
  output logic [IDX_W-1:0] rd_idx
);

  localparam int TBL      = 2 * (ROUNDS + 1);
  localparam int ROW_W    = IDX_W - 1;
  localparam int MIX_N    = 3 * TBL;
  localparam int STEP_W   = $clog2(MIX_N);

  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(TBL - 1);
  localparam logic [STEP_W-1:0] MIX_LAST  = STEP_W'(MIX_N - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ROUNDS);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROUNDS);

  rc5_state_t          state_r, state_nxt;
  logic                table_ready_r, table_ready_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [KW_IDX_W-1:0] j_r, j_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [IDX_W-1:0]    idx_inc;
  logic [ROW_W-1:0]    crypt_row;
  logic                out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign idx_inc   = (idx_r == IDX_LAST) ? '0 : idx_r + IDX_W'(1);
  // Next row to fetch while a round is running.
  assign crypt_row = dec_mode ? (ROW_W'(ROUNDS - 1) - step_r[ROW_W-1:0])
                              : (step_r[ROW_W-1:0] + ROW_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      table_ready_r <= 1'b0;
      out_valid_r   <= 1'b0;
      idx_r         <= '0;
      j_r           <= '0;
      step_r        <= '0;
    end else begin
      state_r       <= state_nxt;
      table_ready_r <= table_ready_nxt;
      out_valid_r   <= out_valid_nxt;
      idx_r         <= idx_nxt;
      j_r           <= j_nxt;
      step_r        <= step_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    table_ready_nxt = table_ready_r;
    idx_nxt         = idx_r;
    j_nxt           = j_r;
    step_nxt        = step_r;
    cmd             = '0;
    wr_idx          = idx_r;
    rd_idx          = '0;
    in_ready        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.blk_load = 1'b1;
          step_nxt     = '0;
          if (table_ready_r) begin
            state_nxt = ST_START;
          end else begin
            cmd.sched_init = 1'b1;
            idx_nxt        = '0;
            j_nxt          = '0;
            state_nxt      = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        cmd.fill_we = 1'b1;
        if (idx_r == IDX_LAST) begin
          // prefetch entry 0 for the first mixing step
          cmd.rd_en = 1'b1;
          rd_idx    = '0;
          idx_nxt   = '0;
          state_nxt = ST_MIX;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_MIX: begin
        cmd.mix_we  = 1'b1;
        cmd.key_idx = j_r;
        j_nxt       = j_r + KW_IDX_W'(1);
        idx_nxt     = idx_inc;
        if (step_r == MIX_LAST) begin
          table_ready_nxt = 1'b1;
          step_nxt        = '0;
          state_nxt       = ST_START;
        end else begin
          cmd.rd_en = 1'b1;
          rd_idx    = idx_inc;
          step_nxt  = step_r + STEP_W'(1);
        end
      end
      ST_START: begin
        cmd.rd_en = 1'b1;
        rd_idx    = {(dec_mode ? ROW_LAST : ROW_W'(0)), 1'b0};
        step_nxt  = '0;
        state_nxt = ST_CRYPT;
      end
      ST_CRYPT: begin
        cmd.crypt_en    = 1'b1;
        cmd.crypt_white = dec_mode ? (step_r == STEP_LAST) : (step_r == '0);
        if (step_r == STEP_LAST) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end else begin
          cmd.rd_en = 1'b1;
          rd_idx    = {crypt_row, 1'b0};
          step_nxt  = step_r + STEP_W'(1);
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // a key write invalidates the expanded table
    if (cfg_we) begin
      table_ready_nxt = 1'b0;
    end
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register loaded while a result is still pending");

  a_key_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !table_ready_r)
    else $error("table still marked ready after key write");

  a_crypt_needs_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_START || state_r == ST_CRYPT) |-> table_ready_r)
    else $error("cipher rounds running without an expanded table");

  a_ready_skips_expand: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && table_ready_r && !cfg_we) |=> (state_r == ST_START))
    else $error("transfer with ready table did not go straight to rounds");
`endif

endmodule

// ----- rtl/rc5_datapath.sv -----
// Datapath for the RC5-16 block cipher: key register, key words, round-key
// table banks, key-mixing unit, shared round unit and result register. Uses rc5_pkg.
module rc5_datapath import rc5_pkg::*; #(
  parameter int ROUNDS = 8,
  parameter int IDX_W  = $clog2(2 * (ROUNDS + 1))
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [KEY_W-1:0]  cfg_data,
  input  logic              in_cmd,
  input  logic [WORD_W-1:0] in_block_a,
  input  logic [WORD_W-1:0] in_block_b,
  input  rc5_cmd_t          cmd,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic              dec_mode,
  output logic [WORD_W-1:0] out_a,
  output logic [WORD_W-1:0] out_b
);

  localparam int ROWS  = ROUNDS + 1;
  localparam int ROW_W = IDX_W - 1;

  logic [KEY_W-1:0]  key_r;
  logic [WORD_W-1:0] kw_r [KEY_WORDS];
  logic [WORD_W-1:0] bank_even [ROWS];
  logic [WORD_W-1:0] bank_odd  [ROWS];
  logic [WORD_W-1:0] rd_even_r, rd_odd_r;
  logic              rd_bank_r;
  logic [WORD_W-1:0] fill_r;
  logic [WORD_W-1:0] sa_r, sb_r;
  logic [WORD_W-1:0] a_r, b_r;
  logic              dec_r;
  logic [WORD_W-1:0] out_a_r, out_b_r;

  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] mix_key, sa_nxt, sb_nxt, sab;
  logic [WORD_W-1:0] enc_a1, enc_b1, dec_a1, dec_b1;
  logic [WORD_W-1:0] a_nxt, b_nxt;

  assign dec_mode = dec_r;
  assign out_a    = out_a_r;
  assign out_b    = out_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      key_r <= cfg_data;
    end
  end

  // Key-mixing step: one table entry and one key word per cycle.
  assign mix_key = rd_bank_r ? rd_odd_r : rd_even_r;
  assign sa_nxt  = rotl16(mix_key + sa_r + sb_r, SCHED_ROT);
  assign sab     = sa_nxt + sb_r;
  assign sb_nxt  = rotl16(kw_r[cmd.key_idx] + sab, sab[3:0]);

  assign wr_data = cmd.fill_we ? fill_r : sa_nxt;

  always_ff @(posedge clk) begin
    if (cmd.sched_init) begin
      fill_r <= MAGIC_P;
      sa_r   <= '0;
      sb_r   <= '0;
      for (int k = 0; k < KEY_WORDS; k++) begin
        kw_r[k] <= key_r[WORD_W*k +: WORD_W];
      end
    end else begin
      if (cmd.fill_we) begin
        fill_r <= fill_r + MAGIC_Q;
      end
      if (cmd.mix_we) begin
        sa_r                <= sa_nxt;
        sb_r                <= sb_nxt;
        kw_r[cmd.key_idx]   <= sb_nxt;
      end
    end
  end

  // Round-key table: even and odd entries in separate banks, one row per round plus one for whitening.
  always_ff @(posedge clk) begin
    if (cmd.fill_we || cmd.mix_we) begin
      if (wr_idx[0]) begin
        bank_odd[wr_idx[IDX_W-1:1]] <= wr_data;
      end else begin
        bank_even[wr_idx[IDX_W-1:1]] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_even_r <= bank_even[rd_idx[IDX_W-1:1]];
      rd_odd_r  <= bank_odd[rd_idx[IDX_W-1:1]];
      rd_bank_r <= rd_idx[0];
    end
  end

  // Shared round unit.
  assign enc_a1 = rotl16(a_r ^ b_r, b_r[3:0]) + rd_even_r;
  assign enc_b1 = rotl16(b_r ^ enc_a1, enc_a1[3:0]) + rd_odd_r;
  assign dec_b1 = rotr16(b_r - rd_odd_r, a_r[3:0]) ^ a_r;
  assign dec_a1 = rotr16(a_r - rd_even_r, dec_b1[3:0]) ^ dec_b1;

  always_comb begin
    unique case ({dec_r, cmd.crypt_white})
      2'b00: begin
        a_nxt = enc_a1;
        b_nxt = enc_b1;
      end
      2'b01: begin
        a_nxt = a_r + rd_even_r;
        b_nxt = b_r + rd_odd_r;
      end
      2'b10: begin
        a_nxt = dec_a1;
        b_nxt = dec_b1;
      end
      default: begin
        a_nxt = a_r - rd_even_r;
        b_nxt = b_r - rd_odd_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.blk_load) begin
      a_r   <= in_block_a;
      b_r   <= in_block_b;
      dec_r <= in_cmd;
    end else if (cmd.crypt_en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  // take the last round straight into the result register when it is free
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_a_r <= cmd.crypt_en ? a_nxt : a_r;
      out_b_r <= cmd.crypt_en ? b_nxt : b_r;
    end
  end

endmodule

// ----- rtl/rc5_block_cipher.sv -----
// RC5-16/ROUNDS/8 block cipher. With the round-key table ready, a block passes
// through an accept, a table fetch and ROUNDS+1 round-unit steps (one per round
// plus whitening) before the next transfer; a pending result holds it in ST_HOLD.
// After reset or a key write the first block adds key expansion (fill plus three
// mixing passes over the round-key table).
// Reset (rst_n, synchronous) clears the key to zero and marks the table stale.
module rc5_block_cipher import rc5_pkg::*; #(
  parameter int ROUNDS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [KEY_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [WORD_W-1:0] in_block_a,
  input  logic [WORD_W-1:0] in_block_b,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_a,
  output logic [WORD_W-1:0] out_b
);

  localparam int IDX_W = $clog2(2 * (ROUNDS + 1));

  rc5_cmd_t         cmd;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic             dec_mode;

  rc5_ctrl #(
    .ROUNDS (ROUNDS),
    .IDX_W  (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dec_mode  (dec_mode),
    .cmd       (cmd),
    .wr_idx    (wr_idx),
    .rd_idx    (rd_idx)
  );

  rc5_datapath #(
    .ROUNDS (ROUNDS),
    .IDX_W  (IDX_W)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_cmd     (in_cmd),
    .in_block_a (in_block_a),
    .in_block_b (in_block_b),
    .cmd        (cmd),
    .wr_idx     (wr_idx),
    .rd_idx     (rd_idx),
    .dec_mode   (dec_mode),
    .out_a      (out_a),
    .out_b      (out_b)
  );

endmodule
